@@ rtl/lks_pkg.sv @@
// Shared constants, types and helpers for the LRU key set.
`default_nettype none

package lks_pkg;

	localparam int CAPACITY  = 8;
	localparam int KEY_WIDTH = 32;
	localparam int RANK_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int OCC_W     = $clog2(CAPACITY + 1);
	localparam int CFG_W     = 4;

	typedef logic signed [KEY_WIDTH-1:0] key_t;
	typedef logic [RANK_W-1:0] rank_t;
	typedef logic [OCC_W-1:0] occ_t;
	typedef logic [CFG_W-1:0] cfg_t;

	typedef struct packed {
		logic access;
		key_t key;
	} lks_req_t;

	typedef struct packed {
		logic hit;
		logic evicted_valid;
		key_t evicted_key;
	} lks_result_t;

	function automatic occ_t clamp_capacity(cfg_t v);
		occ_t r;
		if (v == '0) begin
			r = occ_t'(1);
		end else if (32'(v) > CAPACITY) begin
			r = occ_t'(CAPACITY);
		end else begin
			r = occ_t'(v);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ rtl/lks_store.sv @@
// Key store with recency ranks: parallel lookup, victim choice and update.
`default_nettype none

module lks_store (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lks_pkg::lks_req_t req,
	input  wire logic              cfg_we,
	input  wire lks_pkg::cfg_t     cfg_value,
	output lks_pkg::lks_result_t   result
);
	import lks_pkg::*;

	key_t  keys_q  [CAPACITY];
	logic  valid_q [CAPACITY];
	rank_t rank_q  [CAPACITY];
	occ_t  occ_q;
	occ_t  cap_q;

	logic [CAPACITY-1:0] match;
	logic [CAPACITY-1:0] victim;
	logic [CAPACITY-1:0] first_free;
	logic [CAPACITY-1:0] slot;
	logic                hit;
	logic                full;
	rank_t               hit_rank;
	rank_t               lru_rank;
	key_t                victim_key;
	logic                seen_free;

	always_comb begin
		hit        = 1'b0;
		hit_rank   = '0;
		victim_key = '0;
		seen_free  = 1'b0;
		full       = (occ_q >= cap_q);
		lru_rank   = rank_t'(occ_q - occ_t'(1));
		for (int i = 0; i < CAPACITY; i++) begin
			match[i]      = valid_q[i] && (keys_q[i] == req.key);
			victim[i]     = valid_q[i] && (rank_q[i] == lru_rank);
			first_free[i] = !valid_q[i] && !seen_free;
			if (!valid_q[i]) begin
				seen_free = 1'b1;
			end
			hit = hit | match[i];
			if (match[i]) begin
				hit_rank = hit_rank | rank_q[i];
			end
			if (victim[i]) begin
				victim_key = victim_key | keys_q[i];
			end
		end
		slot = full ? victim : first_free;
		result.hit           = hit;
		result.evicted_valid = !hit && full;
		result.evicted_key   = (!hit && full) ? victim_key : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
			cap_q <= occ_t'(CAPACITY);
			for (int i = 0; i < CAPACITY; i++) begin
				valid_q[i] <= 1'b0;
				rank_q[i]  <= '0;
			end
		end else if (cfg_we) begin
			occ_q <= '0;
			cap_q <= clamp_capacity(cfg_value);
			for (int i = 0; i < CAPACITY; i++) begin
				valid_q[i] <= 1'b0;
				rank_q[i]  <= '0;
			end
		end else if (req.access) begin
			if (hit) begin
				for (int i = 0; i < CAPACITY; i++) begin
					if (match[i]) begin
						rank_q[i] <= '0;
					end else if (valid_q[i] && (rank_q[i] < hit_rank)) begin
						rank_q[i] <= rank_q[i] + rank_t'(1);
					end
				end
			end else begin
				if (!full) begin
					occ_q <= occ_q + occ_t'(1);
				end
				for (int i = 0; i < CAPACITY; i++) begin
					if (slot[i]) begin
						valid_q[i] <= 1'b1;
						rank_q[i]  <= '0;
					end else if (valid_q[i]) begin
						rank_q[i] <= rank_q[i] + rank_t'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!cfg_we && req.access && !hit) begin
			for (int i = 0; i < CAPACITY; i++) begin
				if (slot[i]) begin
					keys_q[i] <= req.key;
				end
			end
		end
	end

	a_occ_within_cap: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= cap_q)
		else $error("occupancy above capacity in use");

	a_single_match: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match))
		else $error("key held in more than one entry");

	a_one_victim: assert property (@(posedge clk) disable iff (!arst_n)
		req.access && !hit && full |-> $onehot(victim))
		else $error("no unique least recently used entry on eviction");

endmodule

`default_nettype wire

@@ rtl/lru_key_set.sv @@
// Top level of the LRU key set: input register, key store and result register.
//
//  channel | handshake             | word
//  --------+-----------------------+-----------------------------------
//  in      | in_valid / in_stall   | key
//  out     | out_valid / out_stall | hit, evicted_valid, evicted_key
//  cfg     | cfg_valid / cfg_ready | capacity_in_use
//
//  One word per cycle unless out_stall holds; a key passes the input register, then the result register.
//  Lookup and victim choice are combinational in the store; the rank update is registered.
//  cfg_ready is high only with both registers empty; a write empties the store.
//  Reset empties the store and sets capacity in use to the built size.
//  A stalled result holds; the input stalls only when both registers are full.
`default_nettype none

module lru_key_set (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire lks_pkg::key_t key,
	output logic               out_valid,
	input  wire logic          out_stall,
	output logic               hit,
	output logic               evicted_valid,
	output lks_pkg::key_t      evicted_key,
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire lks_pkg::cfg_t capacity_in_use
);
	import lks_pkg::*;

	logic        valid_s1;
	key_t        key_s1;
	logic        advance;
	logic        out_valid_q;
	lks_result_t res_q;
	lks_result_t res;
	lks_req_t    req;
	logic        cfg_we;

	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && out_valid_q && out_stall;
	assign cfg_ready = !valid_s1 && !out_valid_q;
	assign cfg_we    = cfg_valid && cfg_ready;

	assign req = '{access: advance, key: key_s1};

	lks_store u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_value (capacity_in_use),
		.result    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			key_s1 <= key;
		end
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign hit           = res_q.hit;
	assign evicted_valid = res_q.evicted_valid;
	assign evicted_key   = res_q.evicted_key;

	a_advance_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("result register not loaded");

	a_no_cfg_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> !advance)
		else $error("configuration write during access");

	a_evict_only_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(res_q.hit && res_q.evicted_valid))
		else $error("eviction reported on a hit");

endmodule

`default_nettype wire
